[hw/rtl/krl_pkg.sv]
// ----------------------------------------------------------------------------
// krl_pkg: shared types and constants for the keyed record list
// Record layout, request and status codes, sequencer states and the
// memory port bundle used between the controller and the record store.
// ----------------------------------------------------------------------------
package krl_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int RIDX_W   = 7;
  localparam int CMP_W    = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
  localparam int TOTAL_W  = 8;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [7:0]         age;
    logic [7:0]         sex;
  } rec_t;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_READ   = 2'd3
  } req_op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    rec_t wdata;
    idx_t raddr;
  } mem_req_t;

endpackage

[hw/rtl/krl_if.sv]
// ----------------------------------------------------------------------------
// krl_if: request and response channels of the keyed record list
// Valid/ready channels; a word moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface krl_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] rec_key;
  logic [7:0]         rec_age;
  logic [7:0]         rec_sex;
  logic [6:0]         read_index;

  modport source(output valid, req_type, rec_key, rec_age, rec_sex, read_index,
                 input ready);
  modport sink(input valid, req_type, rec_key, rec_age, rec_sex, read_index,
               output ready);
endinterface

interface krl_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] out_key;
  logic [7:0]         out_age;
  logic [7:0]         out_sex;
  logic [7:0]         entry_total;

  modport source(output valid, status, out_key, out_age, out_sex, entry_total,
                 input ready);
  modport sink(input valid, status, out_key, out_age, out_sex, entry_total,
               output ready);
endinterface

[hw/rtl/krl_store.sv]
// ----------------------------------------------------------------------------
// krl_store: record memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module krl_store (
  input  logic              clk,
  input  krl_pkg::mem_req_t mem_req,
  output krl_pkg::rec_t     rdata
);
  import krl_pkg::*;

  rec_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    rdata <= mem[mem_req.raddr];
  end

endmodule

[hw/rtl/krl_ctrl.sv]
// ----------------------------------------------------------------------------
// krl_ctrl: request sequencer of the keyed record list
// Walks the record memory one entry per cycle with a single key comparator
// and two pointer adders, compacts the list after a remove, and holds the result.
// ----------------------------------------------------------------------------
module krl_ctrl (
  input  logic              clk,
  input  logic              rst,
  krl_req_if.sink           req,
  krl_rsp_if.source         rsp,
  output krl_pkg::mem_req_t mem_req,
  input  krl_pkg::rec_t     mem_rdata
);
  import krl_pkg::*;

  state_t  state, state_next;
  cnt_t    count;
  cnt_t    ptr;
  req_op_t req_op;
  logic signed [31:0] req_key;
  status_t res_status;
  rec_t    res_rec;
  logic    out_valid;

  logic           accept;
  logic           out_free;
  logic           full;
  logic           idx_ok;
  logic           key_hit;
  logic           more;
  logic [CNT_W:0] ptr_inc;
  logic [CNT_W:0] ptr_step;
  rec_t           in_rec;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign full     = (count == CNT_W'(CAPACITY));
  assign idx_ok   = CMP_W'(req.read_index) < CMP_W'(count);
  assign key_hit  = (mem_rdata.key == req_key);
  assign ptr_inc  = {1'b0, ptr} + (CNT_W+1)'(1);
  assign more     = ptr_inc < {1'b0, count};
  // During a shift the entry after the next one is fetched ahead.
  assign ptr_step = {1'b0, ptr} + ((state == ST_SHIFT) ? (CNT_W+1)'(2) : (CNT_W+1)'(1));

  assign in_rec.key = req.rec_key;
  assign in_rec.age = req.rec_age;
  assign in_rec.sex = req.rec_sex;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_op_t'(req.req_type))
            REQ_APPEND: state_next = ST_DONE;
            REQ_READ:   state_next = idx_ok ? ST_FETCH : ST_DONE;
            default:    state_next = (count == '0) ? ST_DONE : ST_SCAN;
          endcase
        end
      end
      ST_FETCH: state_next = ST_DONE;
      ST_SCAN: begin
        if (key_hit) begin
          state_next = (req_op == REQ_REMOVE) ? ST_SHIFT : ST_DONE;
        end else if (!more) begin
          state_next = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (!more) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready     = (state == ST_IDLE);
    mem_req.we    = 1'b0;
    mem_req.waddr = count[IDX_W-1:0];
    mem_req.wdata = in_rec;
    mem_req.raddr = ptr_step[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        mem_req.raddr = (req_op_t'(req.req_type) == REQ_READ) ? IDX_W'(req.read_index) : '0;
        mem_req.we    = accept && (req_op_t'(req.req_type) == REQ_APPEND) && !full;
      end
      ST_SHIFT: begin
        mem_req.we    = more;
        mem_req.waddr = ptr[IDX_W-1:0];
        mem_req.wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_IDLE && accept && req_op_t'(req.req_type) == REQ_APPEND && !full) begin
        count <= count + CNT_W'(1);
      end else if (state == ST_SHIFT && !more) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          req_op     <= req_op_t'(req.req_type);
          req_key    <= req.rec_key;
          ptr        <= '0;
          res_rec    <= '0;
          res_status <= STAT_OK;
          unique case (req_op_t'(req.req_type))
            REQ_APPEND: begin
              if (full) begin
                res_status <= STAT_FULL;
              end else begin
                res_rec <= in_rec;
              end
            end
            REQ_READ: begin
              if (!idx_ok) begin
                res_status <= STAT_BAD_INDEX;
              end
            end
            default: begin
              if (count == '0) begin
                res_status <= STAT_NOT_FOUND;
              end
            end
          endcase
        end
      end
      ST_FETCH: res_rec <= mem_rdata;
      ST_SCAN: begin
        if (key_hit) begin
          res_rec <= mem_rdata;
        end else if (!more) begin
          res_status <= STAT_NOT_FOUND;
        end else begin
          ptr <= ptr_inc[CNT_W-1:0];
        end
      end
      ST_SHIFT: begin
        if (more) begin
          ptr <= ptr_inc[CNT_W-1:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          rsp.status      <= res_status;
          rsp.out_key     <= res_rec.key;
          rsp.out_age     <= res_rec.age;
          rsp.out_sex     <= res_rec.sex;
          rsp.entry_total <= TOTAL_W'(count);
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid = out_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("record count exceeds capacity");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req_op_t'(req.req_type) == REQ_APPEND && !full)
      |=> count == $past(count) + CNT_W'(1))
    else $error("append did not grow the count");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_SHIFT) |-> count != '0)
    else $error("scan running over an empty list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free && res_status == STAT_FULL)
      |-> count == CNT_W'(CAPACITY))
    else $error("full reported while list has room");

endmodule

[hw/rtl/keyed_record_list.sv]
// ----------------------------------------------------------------------------
// keyed_record_list: fixed-capacity record list in insertion order
// Append, remove by key, lookup by key and read by index over one record RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time and every request returns one response
// word carrying the count after the request. The record memory, with one
// read port, one write port and registered read data, and its one key
// comparator visit one entry per cycle, first scanning for the first match
// and, for a remove, then moving each later entry down one place. A
// finished response waits in an output register, and the request side
// reopens as soon as that register is loaded. Record storage needs no
// clearing after reset.
module keyed_record_list (
  input logic clk,
  input logic rst,
  krl_req_if.sink   req,
  krl_rsp_if.source rsp
);
  import krl_pkg::*;

  mem_req_t mem_req;
  rec_t     mem_rdata;

  krl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  krl_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (mem_rdata)
  );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for keyed_record_list
// Drives append, remove, lookup and read-by-index words into the request
// channel and checks every response word against a behavioral list model,
// or the word a directed row gives; the list drifts between filling and draining.
// ----------------------------------------------------------------------------
module tb;
  import krl_pkg::*;

  localparam int      RANDOM_ITEMS = 950;
  localparam int      MAX_REPORTS  = 20;
  localparam int      TAIL_CYCLES  = 300;
  localparam longint  LIMIT_TIME   = 64'd15_000_000;

  typedef struct packed {
    status_t    status;
    rec_t       rec;
    logic [7:0] total;
  } reply_t;

  typedef struct {
    req_op_t    op;
    rec_t       rec;
    logic [6:0] index;
    bit         typed;
    reply_t     want;
  } stim_row_t;

  logic clk;
  logic rst;

  krl_req_if req_ch();
  krl_rsp_if rsp_ch();

  keyed_record_list uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  rec_t      list_recs [CAPACITY];
  int        list_count;
  reply_t    pending_replies[$];
  stim_row_t directed_rows[$];
  bit        quiet;
  bit        filling;
  int        mismatches;
  int        op_seen[4];
  int        status_seen[4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_TIME);
    $display("%0t: run did not complete in time", $time);
    $display("keyed_record_list test failed");
    $finish;
  end

  function automatic stim_row_t row(req_op_t op, logic [31:0] key, logic [7:0] age,
                                    logic [7:0] sex, logic [6:0] index, bit typed = 1'b0,
                                    status_t st = STAT_OK, logic [7:0] total = 8'd0);
    stim_row_t r;
    r.op          = op;
    r.rec.key     = key;
    r.rec.age     = age;
    r.rec.sex     = sex;
    r.index       = index;
    r.typed       = typed;
    r.want.status = st;
    r.want.rec    = (st == STAT_OK) ? r.rec : '0;
    r.want.total  = total;
    return r;
  endfunction

  // Behavioral list: updates the model state and returns the response word.
  function automatic reply_t apply_request(req_op_t op, rec_t rec, logic [6:0] index);
    reply_t rp;
    int     pos;
    rp        = '0;
    rp.status = STAT_OK;
    case (op)
      REQ_APPEND: begin
        if (list_count < CAPACITY) begin
          list_recs[list_count] = rec;
          list_count++;
          rp.rec = rec;
        end else begin
          rp.status = STAT_FULL;
        end
      end
      REQ_REMOVE, REQ_LOOKUP: begin
        pos = -1;
        for (int i = 0; i < list_count; i++) begin
          if (pos < 0 && list_recs[i].key == rec.key) pos = i;
        end
        if (pos < 0) begin
          rp.status = STAT_NOT_FOUND;
        end else begin
          rp.rec = list_recs[pos];
          if (op == REQ_REMOVE) begin
            for (int i = pos; i + 1 < list_count; i++) list_recs[i] = list_recs[i + 1];
            list_count--;
          end
        end
      end
      default: begin
        if (index < list_count) rp.rec = list_recs[index];
        else rp.status = STAT_BAD_INDEX;
      end
    endcase
    rp.total = list_count[7:0];
    return rp;
  endfunction

  // Most keys come from a small pool or from the list itself, so that
  // duplicates, first-match hits and misses all occur often.
  function automatic stim_row_t pick_request();
    stim_row_t r;
    int        roll;
    roll = $urandom_range(99);
    if (filling)
      r.op = (roll < 55) ? REQ_APPEND : (roll < 65) ? REQ_REMOVE :
             (roll < 80) ? REQ_LOOKUP : REQ_READ;
    else
      r.op = (roll < 10) ? REQ_APPEND : (roll < 60) ? REQ_REMOVE :
             (roll < 80) ? REQ_LOOKUP : REQ_READ;
    roll = $urandom_range(99);
    if (r.op != REQ_APPEND && list_count > 0 && roll < 70)
      r.rec.key = list_recs[$urandom_range(list_count - 1)].key;
    else if (roll < 80)
      r.rec.key = $urandom_range(15);
    else if (roll < 88)
      r.rec.key = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
    else
      r.rec.key = $urandom;
    r.rec.age = 8'($urandom_range(255));
    r.rec.sex = 8'($urandom_range(255));
    if (list_count > 0 && $urandom_range(99) < 60)
      r.index = 7'($urandom_range(list_count - 1));
    else
      r.index = 7'($urandom_range(127));
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  task automatic push_request(input stim_row_t r);
    reply_t predicted;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 15) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= r.op;
    req_ch.rec_key    <= r.rec.key;
    req_ch.rec_age    <= r.rec.age;
    req_ch.rec_sex    <= r.rec.sex;
    req_ch.read_index <= r.index;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = apply_request(r.op, r.rec, r.index);
    pending_replies.push_back(r.typed ? r.want : predicted);
    op_seen[r.op]++;
  endtask

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
    end
  endfunction

  always @(negedge clk) begin
    rsp_ch.ready <= quiet || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: response word arrived with none expected", $time);
      end else begin
        want = pending_replies.pop_front();
        status_seen[want.status]++;
        check_field("status", 32'(want.status), 32'(rsp_ch.status));
        check_field("out_key", want.rec.key, rsp_ch.out_key);
        check_field("out_age", 32'(want.rec.age), 32'(rsp_ch.out_age));
        check_field("out_sex", 32'(want.rec.sex), 32'(rsp_ch.out_sex));
        check_field("entry_total", 32'(want.total), 32'(rsp_ch.entry_total));
      end
    end
  end

  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_APPEND;
    req_ch.rec_key     = '0;
    req_ch.rec_age     = '0;
    req_ch.rec_sex     = '0;
    req_ch.read_index  = '0;
    rsp_ch.ready       = 1'b0;
    quiet              = 1'b0;
    filling            = 1'b1;
    list_count         = 0;
    mismatches         = 0;

    // Empty list: every request fails.
    directed_rows.push_back(row(REQ_LOOKUP, 32'd0, 8'd0, 8'd0, 7'd0, 1'b1,
                                STAT_NOT_FOUND, 8'd0));
    directed_rows.push_back(row(REQ_REMOVE, 32'hffff_ffff, 8'd0, 8'd0, 7'd0, 1'b1,
                                STAT_NOT_FOUND, 8'd0));
    directed_rows.push_back(row(REQ_READ, 32'd0, 8'd0, 8'd0, 7'd0, 1'b1,
                                STAT_BAD_INDEX, 8'd0));
    directed_rows.push_back(row(REQ_READ, 32'd0, 8'd0, 8'd0, 7'd127, 1'b1,
                                STAT_BAD_INDEX, 8'd0));
    // Appends echo the stored record; key 5 goes in twice (ASCII M, then F).
    directed_rows.push_back(row(REQ_APPEND, 32'h8000_0000, 8'd0, 8'd0, 7'd0, 1'b1,
                                STAT_OK, 8'd1));
    directed_rows.push_back(row(REQ_APPEND, 32'h7fff_ffff, 8'd255, 8'd255, 7'd0, 1'b1,
                                STAT_OK, 8'd2));
    directed_rows.push_back(row(REQ_APPEND, 32'd5, 8'd30, 8'd77, 7'd0, 1'b1,
                                STAT_OK, 8'd3));
    directed_rows.push_back(row(REQ_APPEND, 32'd5, 8'd31, 8'd70, 7'd0, 1'b1,
                                STAT_OK, 8'd4));
    directed_rows.push_back(row(REQ_APPEND, 32'hffff_ffff, 8'd128, 8'd127, 7'd0, 1'b1,
                                STAT_OK, 8'd5));
    directed_rows.push_back(row(REQ_LOOKUP, 32'd5, 8'd0, 8'd0, 7'd0));
    directed_rows.push_back(row(REQ_LOOKUP, 32'h7fff_ffff, 8'd0, 8'd0, 7'd0));
    directed_rows.push_back(row(REQ_READ, 32'd0, 8'd0, 8'd0, 7'd0));
    directed_rows.push_back(row(REQ_READ, 32'd0, 8'd0, 8'd0, 7'd4));
    directed_rows.push_back(row(REQ_READ, 32'd0, 8'd0, 8'd0, 7'd5, 1'b1,
                                STAT_BAD_INDEX, 8'd5));
    directed_rows.push_back(row(REQ_READ, 32'd0, 8'd0, 8'd0, 7'd127, 1'b1,
                                STAT_BAD_INDEX, 8'd5));
    directed_rows.push_back(row(REQ_LOOKUP, 32'd6, 8'd0, 8'd0, 7'd0, 1'b1,
                                STAT_NOT_FOUND, 8'd5));
    // Removes: first of two duplicates, the head, the tail, then the last copy.
    directed_rows.push_back(row(REQ_REMOVE, 32'd5, 8'd0, 8'd0, 7'd0));
    directed_rows.push_back(row(REQ_LOOKUP, 32'd5, 8'd0, 8'd0, 7'd0));
    directed_rows.push_back(row(REQ_REMOVE, 32'h8000_0000, 8'd0, 8'd0, 7'd0));
    directed_rows.push_back(row(REQ_REMOVE, 32'hffff_ffff, 8'd0, 8'd0, 7'd0));
    directed_rows.push_back(row(REQ_READ, 32'd0, 8'd0, 8'd0, 7'd0));
    directed_rows.push_back(row(REQ_REMOVE, 32'd5, 8'd0, 8'd0, 7'd0));
    directed_rows.push_back(row(REQ_REMOVE, 32'd5, 8'd0, 8'd0, 7'd0, 1'b1,
                                STAT_NOT_FOUND, 8'd1));
    directed_rows.push_back(row(REQ_APPEND, 32'h5555_5555, 8'haa, 8'h55, 7'h2a, 1'b1,
                                STAT_OK, 8'd2));
    directed_rows.push_back(row(REQ_APPEND, 32'haaaa_aaaa, 8'h55, 8'haa, 7'h55, 1'b1,
                                STAT_OK, 8'd3));

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed_rows[i]) push_request(directed_rows[i]);

    // The list drifts between filling and draining, and once it reaches full or
    // empty it lingers at that end to hit the error paths.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 400 && n < 550);
      if (list_count == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
      else if (list_count == 0 && $urandom_range(3) == 0) filling = 1'b1;
      else if ($urandom_range(99) < 2) filling = !filling;
      push_request(pick_request());
    end
    @(negedge clk) req_ch.valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d appends, %0d removes, %0d lookups and %0d index reads.",
             op_seen[REQ_APPEND], op_seen[REQ_REMOVE], op_seen[REQ_LOOKUP], op_seen[REQ_READ]);
    $display("Responses: %0d ok, %0d full, %0d key missing, %0d index out of range.",
             status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_NOT_FOUND],
             status_seen[STAT_BAD_INDEX]);
    if (mismatches == 0) $display("keyed_record_list test passed");
    else $display("keyed_record_list test failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/krl_pkg.sv
hw/rtl/krl_if.sv
hw/rtl/krl_store.sv
hw/rtl/krl_ctrl.sv
hw/rtl/keyed_record_list.sv
tb/tb.sv
